// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the size class block allocator.
// Expects clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SCBA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("allocator assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define SCBA_ASSERT_NEVER(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("allocator forbidden condition seen");

`endif

// ----- rtl/core/scba_pkg.sv -----
// Shared types and constants for the size class block allocator.
// No dependencies; used by scba_ctrl and size_class_block_allocator.
package scba_pkg;

  localparam int NUM_REG_CLASSES      = 4;
  localparam int HANDLE_BLOCKS        = 64;
  localparam int SIZE_W               = 16;
  localparam int CNT_W                = 7;
  localparam int MAX_CLASSES_DEF      = 4;
  localparam int BLOCKS_PER_CLASS_DEF = 64;
  localparam int REG_COUNT_BASE       = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  typedef enum logic [1:0] {
    CMD_INIT,
    CMD_ALLOC,
    CMD_RELEASE
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK,
    STS_NO_BLOCK,
    STS_BAD_RELEASE
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  typedef struct packed {
    status_e          status;
    logic [1:0]       got_class;
    logic [5:0]       got_block;
    logic [CNT_W-1:0] free_left;
  } res_t;

endpackage

// ----- rtl/core/scba_map_ram.sv -----
// Used-block bitmap memory: one row per size class, registered read.
// Generic; no package dependencies.
module scba_map_ram #(
  parameter int DEPTH  = 4,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/scba_ctrl.sv -----
// Request sequencer: issues bitmap reads, evaluates allocate/release/init,
// writes rows back and keeps free counters. Depends on scba_pkg.
module scba_ctrl #(
  parameter int MAX_CLASSES      = scba_pkg::MAX_CLASSES_DEF,
  parameter int BLOCKS_PER_CLASS = scba_pkg::BLOCKS_PER_CLASS_DEF,
  parameter int MAP_W = (BLOCKS_PER_CLASS < scba_pkg::HANDLE_BLOCKS) ?
                        BLOCKS_PER_CLASS : scba_pkg::HANDLE_BLOCKS,
  parameter int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        in_cmd_i,
  input  logic [scba_pkg::SIZE_W-1:0]       in_size_i,
  input  logic [1:0]                        in_class_i,
  input  logic [5:0]                        in_block_i,
  input  logic [scba_pkg::SIZE_W-1:0]       cls_size_i [MAX_CLASSES],
  input  logic [scba_pkg::CNT_W-1:0]        cls_cnt_i  [MAX_CLASSES],
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output scba_pkg::res_t                    res_o,
  output logic                              mem_rd_en_o,
  output logic [CLS_W-1:0]                  mem_rd_addr_o,
  input  logic [MAP_W-1:0]                  mem_rd_data_i,
  output logic                              mem_wr_en_o,
  output logic [CLS_W-1:0]                  mem_wr_addr_o,
  output logic [MAP_W-1:0]                  mem_wr_data_o
);

  localparam int BLK_W = (MAP_W > 1) ? $clog2(MAP_W) : 1;

  scba_pkg::state_e state_q, state_d;

  logic [1:0]                  cmd_q;
  logic [scba_pkg::SIZE_W-1:0] size_q;
  logic [1:0]                  rcls_q;
  logic [5:0]                  rblk_q;
  logic [CLS_W-1:0]            cls_q, cls_d;
  logic [scba_pkg::CNT_W-1:0]  free_cnt_q [MAX_CLASSES];
  logic [MAX_CLASSES-1:0]      row_vld_q;

  logic                        in_fire, fire;
  logic [MAP_W-1:0]            row, avail;
  logic [scba_pkg::CNT_W-1:0]  cnt_n, cur_free, inc_free;
  logic                        found, class_ok, alloc_hit, last_cls;
  logic                        rc_ok, rb_ok, rel_ok;
  logic [BLK_W-1:0]            hit_idx, blk_sel;

  assign in_fire = in_valid_i && in_ready_o;
  assign fire    = res_valid_o && res_ready_i;

  // Rows never written since reset or init read as all free.
  assign row      = row_vld_q[cls_q] ? mem_rd_data_i : '0;
  assign cnt_n    = cls_cnt_i[cls_q];
  assign cur_free = free_cnt_q[cls_q];
  assign inc_free = (cur_free < scba_pkg::COUNT_MAX) ? cur_free + 7'd1 : cur_free;

  always_comb begin
    for (int b = 0; b < MAP_W; b++) begin
      avail[b] = !row[b] && (7'(b) < cnt_n);
    end
  end

  // Lowest free block of the row under evaluation.
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        found   = 1'b1;
        hit_idx = BLK_W'(b);
      end
    end
  end

  assign class_ok  = (size_q <= cls_size_i[cls_q]) && (cur_free != '0);
  assign alloc_hit = class_ok && found;
  assign last_cls  = (cls_q == CLS_W'(MAX_CLASSES - 1));

  assign rc_ok   = (int'(rcls_q) < MAX_CLASSES);
  assign rb_ok   = ({1'b0, rblk_q} < cnt_n);
  assign blk_sel = rblk_q[BLK_W-1:0];
  assign rel_ok  = rc_ok && rb_ok && row[blk_sel];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      scba_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = scba_pkg::S_EVAL;
        end
      end
      scba_pkg::S_EVAL: begin
        if (fire) begin
          state_d = scba_pkg::S_IDLE;
        end
      end
      default: state_d = scba_pkg::S_IDLE;
    endcase
  end

  // Outputs, memory port and scan pointer.
  always_comb begin
    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;
    res_o         = '{status: scba_pkg::STS_OK, got_class: '0, got_block: '0,
                      free_left: '0};
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = cls_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = cls_q;
    mem_wr_data_o = row;
    cls_d         = cls_q;
    case (state_q)
      scba_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        mem_rd_en_o   = in_valid_i;
        mem_rd_addr_o = (in_cmd_i == scba_pkg::CMD_ALLOC) ? '0 : CLS_W'(in_class_i);
        if (in_fire) begin
          cls_d = mem_rd_addr_o;
        end
      end
      scba_pkg::S_EVAL: begin
        case (cmd_q)
          scba_pkg::CMD_INIT: begin
            res_valid_o = 1'b1;
          end
          scba_pkg::CMD_ALLOC: begin
            if (alloc_hit) begin
              res_valid_o     = 1'b1;
              res_o.got_class = 2'(cls_q);
              res_o.got_block = 6'(hit_idx);
              res_o.free_left = cur_free - 7'd1;
              mem_wr_en_o     = res_ready_i;
              mem_wr_data_o   = row | (MAP_W'(1) << hit_idx);
            end else if (last_cls) begin
              res_valid_o  = 1'b1;
              res_o.status = scba_pkg::STS_NO_BLOCK;
            end else begin
              // Advance to the next class and fetch its row.
              cls_d         = CLS_W'(cls_q + 1'b1);
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = cls_d;
            end
          end
          scba_pkg::CMD_RELEASE: begin
            res_valid_o = 1'b1;
            if (rel_ok) begin
              res_o.got_class = rcls_q;
              res_o.got_block = rblk_q;
              res_o.free_left = inc_free;
              mem_wr_en_o     = res_ready_i;
              mem_wr_data_o   = row & ~(MAP_W'(1) << blk_sel);
            end else begin
              res_o.status = scba_pkg::STS_BAD_RELEASE;
            end
          end
          default: begin
            res_valid_o  = 1'b1;
            res_o.status = scba_pkg::STS_BAD_RELEASE;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= scba_pkg::S_IDLE;
      cls_q     <= '0;
      row_vld_q <= '0;
      for (int c = 0; c < MAX_CLASSES; c++) begin
        free_cnt_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      if (fire) begin
        case (cmd_q)
          scba_pkg::CMD_INIT: begin
            row_vld_q <= '0;
            for (int c = 0; c < MAX_CLASSES; c++) begin
              free_cnt_q[c] <= cls_cnt_i[c];
            end
          end
          scba_pkg::CMD_ALLOC: begin
            if (alloc_hit) begin
              free_cnt_q[cls_q] <= cur_free - 7'd1;
              row_vld_q[cls_q]  <= 1'b1;
            end
          end
          scba_pkg::CMD_RELEASE: begin
            if (rel_ok) begin
              free_cnt_q[cls_q] <= inc_free;
              row_vld_q[cls_q]  <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Request fields; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_cmd_i;
      size_q <= in_size_i;
      rcls_q <= in_class_i;
      rblk_q <= in_block_i;
    end
  end

endmodule

// ----- rtl/core/size_class_block_allocator.sv -----
// Size class block pool allocator, top level. Each request is evaluated after
// a bitmap memory read and its result goes to the output register; an allocate
// adds a read and evaluate step for each class it skips. One request is
// taken at a time: the next is accepted once the last result has left the
// sequencer. Reset clears registers, counters and row valid bits:
// every bitmap row reads as all free at once, with no clearing pass.
module size_class_block_allocator #(
  parameter int MAX_CLASSES      = scba_pkg::MAX_CLASSES_DEF,
  parameter int BLOCKS_PER_CLASS = scba_pkg::BLOCKS_PER_CLASS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // req_size[15:0], req_class[17:16], req_block[23:18]
  input  logic [1:0]  s_axis_tuser_i,   // cmd[1:0]
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // got_class[1:0], got_block[7:2], free_left[14:8], 0
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  // Register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  `include "assert_macros.svh"

  // Bitmap row width: a handle names at most 64 blocks.
  localparam int MAP_W = (BLOCKS_PER_CLASS < scba_pkg::HANDLE_BLOCKS) ?
                         BLOCKS_PER_CLASS : scba_pkg::HANDLE_BLOCKS;
  localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  // Configuration registers: sizes at indexes 0..3, counts at 4..7.
  logic [scba_pkg::SIZE_W-1:0] blk_size_q [scba_pkg::NUM_REG_CLASSES];
  logic [scba_pkg::CNT_W-1:0]  blk_cnt_q  [scba_pkg::NUM_REG_CLASSES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < scba_pkg::NUM_REG_CLASSES; c++) begin
        blk_size_q[c] <= '0;
        blk_cnt_q[c]  <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (int'(cfg_index_i) < scba_pkg::REG_COUNT_BASE) begin
        blk_size_q[cfg_index_i[1:0]] <= cfg_data_i;
      end else begin
        blk_cnt_q[cfg_index_i[1:0]] <= cfg_data_i[scba_pkg::CNT_W-1:0];
      end
    end
  end

  // Per-class size and effective count, read live at each request. Classes
  // without registers have size and count zero and never allocate.
  logic [scba_pkg::SIZE_W-1:0] cls_size [MAX_CLASSES];
  logic [scba_pkg::CNT_W-1:0]  cls_cnt  [MAX_CLASSES];

  for (genvar c = 0; c < MAX_CLASSES; c++) begin : g_cls
    if (c < scba_pkg::NUM_REG_CLASSES) begin : g_reg
      // Clamp the count to the bitmap row width.
      assign cls_size[c] = blk_size_q[c];
      assign cls_cnt[c]  = (blk_cnt_q[c] > 7'(MAP_W)) ? 7'(MAP_W) : blk_cnt_q[c];
    end else begin : g_zero
      assign cls_size[c] = '0;
      assign cls_cnt[c]  = '0;
    end
  end

  // Sequencer and bitmap memory.
  logic                 res_valid, res_ready;
  scba_pkg::res_t       res;
  logic                 mem_rd_en, mem_wr_en;
  logic [CLS_W-1:0]     mem_rd_addr, mem_wr_addr;
  logic [MAP_W-1:0]     mem_rd_data, mem_wr_data;

  scba_ctrl #(
    .MAX_CLASSES      (MAX_CLASSES),
    .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS),
    .MAP_W            (MAP_W),
    .CLS_W            (CLS_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_cmd_i      (s_axis_tuser_i),
    .in_size_i     (s_axis_tdata_i[15:0]),
    .in_class_i    (s_axis_tdata_i[17:16]),
    .in_block_i    (s_axis_tdata_i[23:18]),
    .cls_size_i    (cls_size),
    .cls_cnt_i     (cls_cnt),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data)
  );

  scba_map_ram #(
    .DEPTH  (MAX_CLASSES),
    .WIDTH  (MAP_W),
    .ADDR_W (CLS_W)
  ) u_map_ram (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  // Output register: parts the result side from the request side, so a new
  // request is taken while a finished result still waits downstream.
  logic           out_vld_q;
  scba_pkg::res_t out_res_q;

  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = {1'b0, out_res_q.free_left, out_res_q.got_block,
                            out_res_q.got_class};

  // One request in flight at a time: after an accept, hold off the next one.
  `SCBA_ASSERT(a_one_in_flight,
               (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
  // Reads never overlap a write-back, so no forwarding path is needed.
  `SCBA_ASSERT_NEVER(a_no_rd_wr_overlap, mem_rd_en && mem_wr_en)
  // A failed request carries no handle and no count.
  `SCBA_ASSERT(a_fail_zero,
               (m_axis_tvalid_o && (m_axis_tuser_o != scba_pkg::STS_OK)) |->
               (m_axis_tdata_o == '0))

endmodule
